// ----- hw/rtl/crc_escape_frame_encoder_macros.svh -----
// ----------------------------------------------------------------------------
// crc escape frame encoder assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CRC_ESCAPE_FRAME_ENCODER_MACROS_SVH
`define CRC_ESCAPE_FRAME_ENCODER_MACROS_SVH

// same-cycle implication
`define CEFE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cefe same-cycle check failed");

// next-cycle implication
`define CEFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cefe next-cycle check failed");

`endif

// ----- hw/rtl/cefe_pkg.sv -----
// ----------------------------------------------------------------------------
// cefe_pkg
// shared constants, command and status types and the crc byte update
// ----------------------------------------------------------------------------
package cefe_pkg;

    localparam int FRAME_BYTES_DEF = 48;
    localparam int BYTE_W          = 8;
    localparam int FILL_W          = 6;
    localparam int MAX_RESULTS     = 58;
    localparam int CNT_W           = 6;
    localparam int CRC_W           = 32;
    localparam int CRC_BYTES       = 4;
    localparam int K_W             = 3;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [BYTE_W-1:0] BYTE_ESC     = 8'h99;
    localparam logic [BYTE_W-1:0] BYTE_PAD     = 8'h9A;
    localparam logic [BYTE_W-1:0] BYTE_HEAD    = 8'h9B;
    localparam logic [BYTE_W-1:0] BYTE_CLOSE   = 8'h9C;
    localparam logic [BYTE_W-1:0] BYTE_MARK    = 8'h9D;
    localparam logic [BYTE_W-1:0] BYTE_ESC_XOR = 8'h10;

    typedef logic [2:0] op_t;
    localparam op_t OP_NONE  = 3'd0;
    localparam op_t OP_MARK  = 3'd1;
    localparam op_t OP_HEAD  = 3'd2;
    localparam op_t OP_DATA  = 3'd3;
    localparam op_t OP_PAD   = 3'd4;
    localparam op_t OP_CLOSE = 3'd5;

    typedef struct packed {
        logic load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic slot_free;
        logic marker_pending;
        logic frame_open;
        logic pad_needed;
        logic more_data;
        logic msg_last;
    } sts_t;

    // reflected crc-32 over one byte, bit at a time
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int i = 0; i < BYTE_W; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/cefe_ctrl.sv -----
// ----------------------------------------------------------------------------
// cefe_ctrl
// sequencer: picks the next byte kind to emit for each input request
// ----------------------------------------------------------------------------
module cefe_ctrl
    import cefe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EMIT = 2'd1;
    localparam logic [1:0] S_PAD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.slot_free)
                begin
                    if (sts.marker_pending)
                        cmd.op = OP_MARK;
                    else if (!sts.frame_open)
                        cmd.op = OP_HEAD;
                    else
                    begin
                        cmd.op = OP_DATA;
                        if (!sts.more_data)
                            state_next = sts.msg_last ? S_PAD : S_IDLE;
                    end
                end
            end
            S_PAD:
            begin
                if (sts.slot_free)
                begin
                    if (sts.pad_needed)
                        cmd.op = OP_PAD;
                    else
                    begin
                        cmd.op     = OP_CLOSE;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- hw/rtl/cefe_datapath.sv -----
// ----------------------------------------------------------------------------
// cefe_datapath
// crc, escape and framing state with the output byte register
// ----------------------------------------------------------------------------
`include "crc_escape_frame_encoder_macros.svh"

module cefe_datapath
    import cefe_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              msg_last,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              frame_end,
    output logic              message_end,
    output logic              run_end
);

    localparam logic [FILL_W-1:0] DATA_BYTES = FILL_W'(FRAME_BYTES - 2);

    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg,    last_next;
    logic [K_W-1:0]    k_reg,       k_next;
    logic              esc_reg,     esc_next;
    logic [CRC_W-1:0]  crc_reg,     crc_next;
    logic [FILL_W-1:0] fill_reg,    fill_next;
    logic              open_reg,    open_next;
    logic              pending_reg, pending_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              ovalid_reg,  ovalid_next;
    logic [BYTE_W-1:0] obyte_reg;
    logic              ofend_reg, omend_reg, orun_reg;

    logic [CRC_W-1:0]  crc_fin;
    logic [1:0]        crc_idx;
    logic [BYTE_W-1:0] raw;
    logic              needs_esc;
    logic [BYTE_W-1:0] data_byte;
    logic              more_data;
    logic [FILL_W-1:0] fill_inc;
    logic              slot_free;
    logic              fire;
    logic              store;
    logic [BYTE_W-1:0] e_byte;
    logic              e_fend, e_mend, e_last;

    // current raw data byte: the message byte, then the inverted crc lsb first
    assign crc_fin   = ~crc_reg;
    assign crc_idx   = 2'(k_reg - K_W'(1));
    assign raw       = (k_reg == '0) ? byte_reg : BYTE_W'(crc_fin >> {crc_idx, 3'b000});
    assign needs_esc = (raw >= BYTE_ESC) && (raw <= BYTE_MARK);
    assign data_byte = esc_reg ? (raw ^ BYTE_ESC_XOR) : (needs_esc ? BYTE_ESC : raw);
    assign more_data = (!esc_reg && needs_esc) || (last_reg && (k_reg < K_W'(CRC_BYTES)));
    assign fill_inc  = fill_reg + FILL_W'(1);

    assign slot_free = !ovalid_reg || out_ready;
    assign fire      = (cmd.op != OP_NONE);
    assign store     = fire && (count_reg < CNT_W'(MAX_RESULTS));

    assign sts.slot_free      = slot_free;
    assign sts.marker_pending = pending_reg;
    assign sts.frame_open     = open_reg;
    assign sts.pad_needed     = !pending_reg && (fill_reg < DATA_BYTES);
    assign sts.more_data      = more_data;
    assign sts.msg_last       = last_reg;

    always_comb
    begin
        e_byte = data_byte;
        e_fend = 1'b0;
        e_mend = 1'b0;
        e_last = 1'b0;
        case (cmd.op)
            OP_MARK:
            begin
                e_byte = BYTE_MARK;
                e_fend = 1'b1;
            end
            OP_HEAD:  e_byte = BYTE_HEAD;
            OP_DATA:  e_last = !more_data && !last_reg;
            OP_PAD:   e_byte = BYTE_PAD;
            OP_CLOSE:
            begin
                e_byte = BYTE_CLOSE;
                e_fend = 1'b1;
                e_mend = 1'b1;
                e_last = 1'b1;
            end
            default:  e_byte = data_byte;
        endcase
    end

    always_comb
    begin
        last_next    = last_reg;
        k_next       = k_reg;
        esc_next     = esc_reg;
        crc_next     = crc_reg;
        fill_next    = fill_reg;
        open_next    = open_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        ovalid_next  = ovalid_reg;

        if (out_ready)
            ovalid_next = 1'b0;

        if (cmd.load)
        begin
            last_next  = msg_last;
            k_next     = '0;
            esc_next   = 1'b0;
            crc_next   = crc_byte(crc_reg, in_byte);
            count_next = '0;
        end

        if (fire)
        begin
            ovalid_next = store;
            if (store)
                count_next = count_reg + CNT_W'(1);
        end

        case (cmd.op)
            OP_MARK:
            begin
                pending_next = 1'b0;
                open_next    = 1'b0;
            end
            OP_HEAD:
            begin
                open_next = 1'b1;
                fill_next = '0;
            end
            OP_DATA:
            begin
                fill_next = fill_inc;
                if (fill_inc >= DATA_BYTES)
                    pending_next = 1'b1;
                if (!esc_reg && needs_esc)
                    esc_next = 1'b1;
                else
                begin
                    esc_next = 1'b0;
                    k_next   = k_reg + K_W'(1);
                end
            end
            OP_PAD:   fill_next = fill_inc;
            OP_CLOSE:
            begin
                crc_next     = CRC_INIT;
                fill_next    = '0;
                open_next    = 1'b0;
                pending_next = 1'b0;
            end
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= 1'b0;
            k_reg       <= '0;
            esc_reg     <= 1'b0;
            crc_reg     <= CRC_INIT;
            fill_reg    <= '0;
            open_reg    <= 1'b0;
            pending_reg <= 1'b0;
            count_reg   <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            last_reg    <= last_next;
            k_reg       <= k_next;
            esc_reg     <= esc_next;
            crc_reg     <= crc_next;
            fill_reg    <= fill_next;
            open_reg    <= open_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            byte_reg <= in_byte;
        if (store)
        begin
            obyte_reg <= e_byte;
            ofend_reg <= e_fend;
            omend_reg <= e_mend;
            orun_reg  <= e_last || (count_reg == CNT_W'(MAX_RESULTS - 1));
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_byte    = obyte_reg;
    assign frame_end   = ofend_reg;
    assign message_end = omend_reg;
    assign run_end     = orun_reg;

    `CEFE_ASSERT_IMPL(a_pending_open, pending_reg, open_reg)
    `CEFE_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= DATA_BYTES)
    `CEFE_ASSERT_IMPL(a_msg_end_closes, ovalid_reg && omend_reg, ofend_reg && orun_reg)
    `CEFE_ASSERT_NEXT(a_close_resets, cmd.op == OP_CLOSE, crc_reg == CRC_INIT && !open_reg)

endmodule

// ----- hw/rtl/crc_escape_frame_encoder.sv -----
// ----------------------------------------------------------------------------
// crc_escape_frame_encoder
// crc-32 byte-stuffing fixed-frame encoder, top level
// ----------------------------------------------------------------------------
// Message bytes come in one per request on the slave side, the final one
// flagged by s_axis_tlast. A reflected crc-32 (init all ones, final
// inversion) runs over the raw bytes; bytes 0x99..0x9d go out as 0x99 then
// the byte xor 0x10, and after the final byte the four crc bytes follow,
// least significant first, escaped alike. The stream is cut into frames of
// FRAME_BYTES: 0x9b, FRAME_BYTES-2 data bytes (0x9a padding in the closing
// frame) and an end byte, 0x9c on the closing frame, 0x9d otherwise; the end
// byte of a full frame is held back until the next data byte or the message
// end decides which it is. An input is accepted, then each output byte it
// produces (header, end bytes, escapes, and after the final byte its crc
// bytes, the padding of the closing frame and the closing end byte) goes
// through the single output byte register, one byte per cycle while the
// master side is ready; the next input is accepted only once the last
// output byte of the current one is in that register. Back-pressure on
// the master side holds the sequencer.
// ----------------------------------------------------------------------------
module crc_escape_frame_encoder
    import cefe_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF   // 4 .. 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,       // [7:0] in_byte
    input  logic              s_axis_tlast,       // msg_last
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata,       // [7:0] out_byte
    output logic [1:0]        m_axis_tuser,       // [0] frame_end, [1] message_end
    output logic              m_axis_tlast        // run_end: last byte of this request
);

    cmd_t cmd;
    sts_t sts;
    logic frame_end;
    logic message_end;

    // sequencer: decides mark / header / data / padding / close
    cefe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // crc, escaping, frame fill and the output register
    cefe_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_byte     (s_axis_tdata),
        .msg_last    (s_axis_tlast),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .frame_end   (frame_end),
        .message_end (message_end),
        .run_end     (m_axis_tlast)
    );

    assign m_axis_tuser = {message_end, frame_end};

endmodule

// ----- sim/crc_escape_frame_encoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_escape_frame_encoder_tb
// ----------------------------------------------------------------------------
// Self-checking bench for the crc-32 byte-stuffing frame encoder. A table of
// directed requests walks the escape range, the byte extremes, a frame that
// fills exactly (held end byte) and short messages. Random messages of mixed
// length follow, biased towards escaped bytes. Every accepted request goes
// through a behavioural encoder model; its output bytes are queued and each
// output request is checked field by field against the oldest one. Both
// sides idle at random, the output side holds off once for a long stretch,
// and the input side drains the block completely now and then.
// ----------------------------------------------------------------------------
module crc_escape_frame_encoder_tb;

    import cefe_pkg::*;

    localparam int DATA_BYTES     = FRAME_BYTES_DEF - 2;
    localparam int DIR_ROWS       = 27;
    localparam int TOTAL_REQUESTS = 270;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_AFTER     = 60;
    localparam int TAIL_CYCLES    = 16;

    // one output byte as the block should present it
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              frame_end;
        logic              msg_end;
        logic              run_end;
    } enc_byte_t;

    // directed row: request plus optional hand-typed output bytes
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              msg_last;
        logic [1:0]        n_typed;     // 0: use the model
        logic [BYTE_W-1:0] e0;
        logic [BYTE_W-1:0] e1;
        logic [BYTE_W-1:0] e2;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [BYTE_W-1:0] m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              m_axis_tlast;

    // encoder model state
    logic [CRC_W-1:0]  crc_reg;
    int unsigned       fill_count;
    bit                header_sent;
    bit                end_held;

    enc_byte_t         step_bytes[$];      // output of the request being modelled
    enc_byte_t         expected_bytes[$];  // outstanding output bytes, oldest first

    stim_row_t         dir_rows [DIR_ROWS];

    int unsigned       requests_sent;
    int unsigned       messages_sent;
    int unsigned       bytes_checked;
    int unsigned       frames_closed;
    int unsigned       fault_count;
    int unsigned       idle_cycles;
    bit                hold_done;

    crc_escape_frame_encoder DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // encoder model
    // ------------------------------------------------------------------------
    function automatic void model_reset();
        crc_reg     = CRC_INIT;
        fill_count  = 0;
        header_sent = 1'b0;
        end_held    = 1'b0;
    endfunction

    function automatic void emit(input logic [BYTE_W-1:0] b, input logic fe, input logic me);
        enc_byte_t r;
        // a single request never yields more than the cap
        if (step_bytes.size() >= MAX_RESULTS)
            return;
        r.data      = b;
        r.frame_end = fe;
        r.msg_end   = me;
        r.run_end   = 1'b0;
        step_bytes.push_back(r);
    endfunction

    // one byte of the escaped stream into the framer
    function automatic void frame_byte(input logic [BYTE_W-1:0] b);
        // full frame waiting: more data means it was not the last one
        if (end_held)
        begin
            emit(BYTE_MARK, 1'b1, 1'b0);
            end_held    = 1'b0;
            header_sent = 1'b0;
        end
        if (!header_sent)
        begin
            emit(BYTE_HEAD, 1'b0, 1'b0);
            header_sent = 1'b1;
            fill_count  = 0;
        end
        emit(b, 1'b0, 1'b0);
        fill_count = (fill_count + 1) % 64;
        if (fill_count >= DATA_BYTES)
            end_held = 1'b1;
    endfunction

    function automatic void stuff_byte(input logic [BYTE_W-1:0] b);
        if (b >= BYTE_ESC && b <= BYTE_MARK)
        begin
            frame_byte(BYTE_ESC);
            frame_byte(b ^ BYTE_ESC_XOR);
        end
        else
            frame_byte(b);
    endfunction

    // reflected crc, one data bit at a time
    function automatic void crc_feed(input logic [BYTE_W-1:0] b);
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (crc_reg[0] ^ b[i])
                crc_reg = (crc_reg >> 1) ^ CRC_POLY;
            else
                crc_reg = crc_reg >> 1;
        end
    endfunction

    function automatic void encode_step(input logic [BYTE_W-1:0] b, input logic msg_last);
        logic [CRC_W-1:0] fcs;
        step_bytes.delete();
        crc_feed(b);
        stuff_byte(b);
        if (msg_last)
        begin
            fcs = ~crc_reg;
            for (int k = 0; k < CRC_BYTES; k++)
                stuff_byte(fcs[8*k +: 8]);
            // a frame that filled exactly needs no padding
            if (!end_held)
            begin
                while (fill_count < DATA_BYTES)
                begin
                    emit(BYTE_PAD, 1'b0, 1'b0);
                    fill_count++;
                end
            end
            emit(BYTE_CLOSE, 1'b1, 1'b1);
            model_reset();
        end
    endfunction

    // tag the last byte of the request and queue the lot
    function automatic void queue_step();
        if (step_bytes.size() > 0)
            step_bytes[step_bytes.size()-1].run_end = 1'b1;
        foreach (step_bytes[i])
            expected_bytes.push_back(step_bytes[i]);
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    function automatic bit sender_quiet();
        return requests_sent >= 120 && requests_sent < 180;
    endfunction

    task automatic offer_request(input logic [BYTE_W-1:0] b, input logic msg_last);
        while (!sender_quiet() && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= msg_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        requests_sent++;
        if (msg_last)
            messages_sent++;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic msg_last);
        offer_request(b, msg_last);
        encode_step(b, msg_last);
        queue_step();
    endtask

    // stop offering until the block has handed out everything owed
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_bytes.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // output side: random stalls, one long hold-off once traffic is flowing
    // ------------------------------------------------------------------------
    initial
    begin
        m_axis_tready <= 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && requests_sent >= HOLD_AFTER)
            begin
                // input keeps coming, so the block backs up and stalls it
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            else if (bytes_checked >= 600 && bytes_checked < 900)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 16);
        end
    end

    // ------------------------------------------------------------------------
    // output checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_output
        enc_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            bytes_checked++;
            if (m_axis_tuser[0])
                frames_closed++;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected output byte %02h tuser %b tlast %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fault_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.data)
                begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, want.data, m_axis_tdata);
                    fault_count++;
                end
                if (m_axis_tuser[0] !== want.frame_end)
                begin
                    $display("%0t: frame_end expected %b actual %b",
                             $time, want.frame_end, m_axis_tuser[0]);
                    fault_count++;
                end
                if (m_axis_tuser[1] !== want.msg_end)
                begin
                    $display("%0t: message_end expected %b actual %b",
                             $time, want.msg_end, m_axis_tuser[1]);
                    fault_count++;
                end
                if (m_axis_tlast !== want.run_end)
                begin
                    $display("%0t: run_end expected %b actual %b",
                             $time, want.run_end, m_axis_tlast);
                    fault_count++;
                end
            end
        end
    end

    // watchdog: too long without any request on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d bytes still owed",
                     $time, WATCHDOG_LIMIT, expected_bytes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int               pick;
        int               msg_len;
        logic [BYTE_W-1:0] b;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        requests_sent = 0;
        messages_sent = 0;
        bytes_checked = 0;
        frames_closed = 0;
        fault_count   = 0;
        idle_cycles   = 0;
        model_reset();

        // first row relies on a fresh frame after reset; the escape rows
        // then fill the data area exactly so the end byte is held
        dir_rows = '{
            '{8'h00,      1'b0, 2'd2, BYTE_HEAD, 8'h00, 8'h00},
            '{8'hFF,      1'b0, 2'd1, 8'hFF,     8'h00, 8'h00},
            '{BYTE_ESC,   1'b0, 2'd2, BYTE_ESC,  8'h89, 8'h00},
            '{BYTE_MARK,  1'b0, 2'd2, BYTE_ESC,  8'h8D, 8'h00},
            '{8'h98,      1'b0, 2'd1, 8'h98,     8'h00, 8'h00},
            '{8'h9E,      1'b0, 2'd1, 8'h9E,     8'h00, 8'h00},
            '{BYTE_PAD,   1'b0, 2'd2, BYTE_ESC,  8'h8A, 8'h00},
            '{BYTE_HEAD,  1'b0, 2'd2, BYTE_ESC,  8'h8B, 8'h00},
            '{BYTE_CLOSE, 1'b0, 2'd2, BYTE_ESC,  8'h8C, 8'h00},
            '{BYTE_ESC,   1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_PAD,   1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_HEAD,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_CLOSE, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_MARK,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_ESC,   1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_PAD,   1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_HEAD,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_CLOSE, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_MARK,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_ESC,   1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_PAD,   1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_HEAD,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_CLOSE, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_MARK,  1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            '{BYTE_ESC,   1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
            // held end byte released as a plain frame end, then the crc
            '{8'h00,      1'b1, 2'd0, 8'h00, 8'h00, 8'h00},
            // one-byte message: all crc plus padding in a single frame
            '{8'h55,      1'b1, 2'd0, 8'h00, 8'h00, 8'h00}
        };

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            offer_request(dir_rows[i].data, dir_rows[i].msg_last);
            encode_step(dir_rows[i].data, dir_rows[i].msg_last);
            if (dir_rows[i].n_typed != 0)
            begin
                step_bytes.delete();
                emit(dir_rows[i].e0, 1'b0, 1'b0);
                if (dir_rows[i].n_typed > 1)
                    emit(dir_rows[i].e1, 1'b0, 1'b0);
                if (dir_rows[i].n_typed > 2)
                    emit(dir_rows[i].e2, 1'b0, 1'b0);
            end
            queue_step();
        end
        drain_results();

        // random messages, mostly short, a few spanning several frames
        while (requests_sent < TOTAL_REQUESTS)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
                msg_len = $urandom_range(12, 1);
            else if (pick < 95)
                msg_len = $urandom_range(60, 13);
            else
                msg_len = $urandom_range(140, 61);
            // keep the total close to the planned request count
            if (msg_len > int'(TOTAL_REQUESTS - requests_sent))
                msg_len = int'(TOTAL_REQUESTS - requests_sent);
            for (int k = 0; k < msg_len; k++)
            begin
                if ($urandom_range(3) == 0)
                    b = BYTE_W'($urandom_range(BYTE_MARK, BYTE_ESC));
                else
                    b = BYTE_W'($urandom_range(255));
                send_byte(b, k == msg_len - 1);
            end
            // no drain before the long hold-off, so input keeps coming then
            if (hold_done && $urandom_range(9) == 0)
                drain_results();
        end
        s_axis_tvalid <= 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("run covered %0d requests in %0d messages", requests_sent, messages_sent);
        $display("checked %0d output bytes across %0d frames", bytes_checked, frames_closed);
        if (fault_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
